>>> rtl/core/two_bit_huffman_decoder_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the two-bit Huffman decoder
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TWO_BIT_HUFFMAN_DECODER_ASSERT_SVH
`define TWO_BIT_HUFFMAN_DECODER_ASSERT_SVH

// same-cycle implication
`define TBHD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TBHD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/tbhd_pkg.sv
// ---------------------------------------------------------------------------
// tbhd_pkg
// Types and constants of the two-bit Huffman decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package tbhd_pkg;

  localparam int unsigned LIMIT_W       = 17;
  localparam int unsigned MAX_OUT_BYTES = 65536;
  localparam int unsigned RES_DEPTH     = 4;
  localparam int unsigned RES_PTR_W     = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W     = $clog2(RES_DEPTH + 1);

  // one result word
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       fin;
  } res_t;

  // 3-bit code window -> rank (codes 0, 10, 110, 111)
  function automatic logic [1:0] code_to_rank(input logic [2:0] code);
    logic [1:0] r;
    unique case (code)
      3'b010:  r = 2'd1;
      3'b110:  r = 2'd2;
      3'b111:  r = 2'd3;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/two_bit_huffman_decoder.sv
// ---------------------------------------------------------------------------
// two_bit_huffman_decoder
// Static prefix-code decoder for 2-bit symbols, one compressed byte a word.
// ---------------------------------------------------------------------------
//
//  channel | dir | words                     | handshake
//  --------+-----+---------------------------+----------------------
//  in_     | in  | compressed byte + tlast   | in_tvalid/in_tready
//  out_    | out | decoded byte/status       | out_tvalid/out_tready
//  cfg_    | in  | out_limit (17 bits)       | cfg_valid/cfg_ready
//
//  One input word per cycle while in_tready is high. The decode of all 8
//  bits of a word is one pass of shallow logic from the state registers
//  into a 4-entry result queue. A word yields 0..2 results; the queue
//  drains one result per cycle while out_tready is high.
//  in_tready is high while the queue has room for two results.
//  Synchronous active-low reset: out_limit = 65536, block state cleared,
//  queue emptied. cfg_ready is always high.
// ---------------------------------------------------------------------------
`default_nettype none

module two_bit_huffman_decoder
  import tbhd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input stream
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,   // [7:0] in_byte
  input  wire logic               in_tlast,   // last_in
  // result stream
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [7:0]              out_tdata,  // [7:0] out_byte
  output logic                    out_tuser,  // [0] has_byte
  output logic                    out_tlast,  // final_res
  // config
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [LIMIT_W-1:0] cfg_data    // out_limit
);

  // ---- block state ----
  logic [LIMIT_W-1:0] out_limit_r;
  logic               hdr_seen_r, hdr_seen_nxt;
  logic [1:0]         rank_r [4];
  logic [1:0]         rank_nxt [4];
  logic [2:0]         cbits_r, cbits_nxt;
  logic [1:0]         clen_r, clen_nxt;
  logic [7:0]         asm_r, asm_nxt;
  logic [1:0]         slot_r, slot_nxt;
  logic [LIMIT_W-1:0] emitted_r, emitted_nxt;
  logic               halted_r, halted_nxt;

  // ---- result queue ----
  res_t               q_mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_r, rd_r;
  logic [RES_CNT_W-1:0] cnt_r;

  logic               in_fire, out_fire;
  logic [LIMIT_W-1:0] lim;
  logic               hit1, hit2;
  res_t               res0, res1;
  logic [1:0]         nres;

  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign cfg_ready = 1'b1;
  assign in_tready = cnt_r <= RES_CNT_W'(RES_DEPTH - 2);

  // limit in force
  assign lim  = (out_limit_r > LIMIT_W'(MAX_OUT_BYTES)) ? LIMIT_W'(MAX_OUT_BYTES)
                                                        : out_limit_r;
  // limit reached after the first / second byte of this word
  assign hit1 = (emitted_r + LIMIT_W'(1)) >= lim;
  assign hit2 = (emitted_r + LIMIT_W'(2)) >= lim;

  // ---- single-pass decode of one word ----
  always_comb begin
    logic [2:0] cb;
    logic [1:0] cl;
    logic [7:0] ab;
    logic [1:0] sl;
    logic [1:0] sym;
    logic       bv;
    logic       stop;
    logic [1:0] rk [4];
    logic [2:0] bi;

    hdr_seen_nxt = hdr_seen_r;
    for (int i = 0; i < 4; i++) rank_nxt[i] = rank_r[i];
    cbits_nxt   = cbits_r;
    clen_nxt    = clen_r;
    asm_nxt     = asm_r;
    slot_nxt    = slot_r;
    emitted_nxt = emitted_r;
    halted_nxt  = halted_r;
    res0        = '0;
    res1        = '0;
    nres        = 2'd0;

    cb   = cbits_r;
    cl   = clen_r;
    ab   = asm_r;
    sl   = slot_r;
    sym  = 2'd0;
    bv   = 1'b0;
    stop = 1'b0;
    bi   = 3'd0;
    for (int i = 0; i < 4; i++) rk[i] = rank_r[i];

    if (in_fire && !halted_r) begin
      if (emitted_r >= lim) begin
        // already at limit: one status word, nothing decoded
        halted_nxt = 1'b1;
        res0       = '{data: 8'd0, has: 1'b0, fin: 1'b1};
        nres       = 2'd1;
      end else begin
        if (!hdr_seen_r) begin
          rk[0] = in_tdata[7:6];
          rk[1] = in_tdata[5:4];
          rk[2] = in_tdata[3:2];
          rk[3] = 2'd0;
          // highest symbol none of the three names
          for (int i = 0; i < 4; i++) begin
            if (rk[0] != 2'(i) && rk[1] != 2'(i) && rk[2] != 2'(i)) rk[3] = 2'(i);
          end
        end
        // MSB first; the header word carries only its low two code bits
        for (int b = 7; b >= 0; b--) begin
          bi = 3'(b);
          if (!stop && (hdr_seen_r || bi < 3'd2)) begin
            bv = in_tdata[bi];
            cb = {cb[1:0], bv};
            cl = cl + 2'd1;
            if (!bv || cl == 2'd3) begin
              sym = rk[code_to_rank(cb)];
              ab  = ab | (8'(sym) << {sl, 1'b0});
              cb  = 3'd0;
              cl  = 2'd0;
              if (sl == 2'd3) begin
                if (nres == 2'd0) res0 = '{data: ab, has: 1'b1, fin: 1'b0};
                else              res1 = '{data: ab, has: 1'b1, fin: 1'b0};
                nres = nres + 2'd1;
                ab   = 8'd0;
                sl   = 2'd0;
                if ((nres == 2'd1 && hit1) || (nres == 2'd2 && hit2)) stop = 1'b1;
              end else begin
                sl = sl + 2'd1;
              end
            end
          end
        end
        hdr_seen_nxt = 1'b1;
        for (int i = 0; i < 4; i++) rank_nxt[i] = rk[i];
        cbits_nxt   = cb;
        clen_nxt    = cl;
        asm_nxt     = ab;
        slot_nxt    = sl;
        emitted_nxt = emitted_r + LIMIT_W'(nres);
        halted_nxt  = stop;
        // flag the block's last result
        if (stop || in_tlast) begin
          if (nres == 2'd0) begin
            res0 = '{data: 8'd0, has: 1'b0, fin: 1'b1};
            nres = 2'd1;
          end else if (nres == 2'd1) begin
            res0.fin = 1'b1;
          end else begin
            res1.fin = 1'b1;
          end
        end
      end
    end

    // end of block: clear for the next one
    if (in_fire && in_tlast) begin
      hdr_seen_nxt = 1'b0;
      for (int i = 0; i < 4; i++) rank_nxt[i] = 2'd0;
      cbits_nxt   = 3'd0;
      clen_nxt    = 2'd0;
      asm_nxt     = 8'd0;
      slot_nxt    = 2'd0;
      emitted_nxt = '0;
      halted_nxt  = 1'b0;
    end
  end

  // ---- state registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_limit_r <= LIMIT_W'(65536);
      hdr_seen_r  <= 1'b0;
      for (int i = 0; i < 4; i++) rank_r[i] <= 2'd0;
      cbits_r     <= 3'd0;
      clen_r      <= 2'd0;
      asm_r       <= 8'd0;
      slot_r      <= 2'd0;
      emitted_r   <= '0;
      halted_r    <= 1'b0;
      wr_r        <= '0;
      rd_r        <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) out_limit_r <= cfg_data;
      hdr_seen_r <= hdr_seen_nxt;
      for (int i = 0; i < 4; i++) rank_r[i] <= rank_nxt[i];
      cbits_r    <= cbits_nxt;
      clen_r     <= clen_nxt;
      asm_r      <= asm_nxt;
      slot_r     <= slot_nxt;
      emitted_r  <= emitted_nxt;
      halted_r   <= halted_nxt;
      wr_r       <= wr_r + RES_PTR_W'(nres);
      if (out_fire) rd_r <= rd_r + RES_PTR_W'(1);
      cnt_r      <= cnt_r + RES_CNT_W'(nres) - RES_CNT_W'(out_fire);
    end
  end

  // ---- result queue storage ----
  always_ff @(posedge clk) begin
    if (nres != 2'd0) q_mem[wr_r] <= res0;
    if (nres == 2'd2) q_mem[wr_r + RES_PTR_W'(1)] <= res1;
  end

  assign out_tvalid = cnt_r != '0;
  assign out_tdata  = q_mem[rd_r].data;
  assign out_tuser  = q_mem[rd_r].has;
  assign out_tlast  = q_mem[rd_r].fin;

  // ---- checks ----
`include "two_bit_huffman_decoder_assert.svh"

  `TBHD_ASSERT_IMP(a_q_bound, 1'b1, cnt_r <= RES_CNT_W'(RES_DEPTH), "result queue overflow")
  `TBHD_ASSERT_IMP(a_halt_quiet, in_fire && halted_r, nres == 2'd0, "result after halt")
  `TBHD_ASSERT_IMP(a_status_final, nres != 2'd0 && !res0.has, res0.fin,
                   "status word without final flag")
  `TBHD_ASSERT_NXT(a_block_clear, in_fire && in_tlast, !hdr_seen_r && !halted_r,
                   "block state not cleared after last word")

endmodule

`default_nettype wire
